FILE: hdl/ubxnmea_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ubxnmea_pkg;

    localparam int BUFFER_BYTES = 512;
    localparam int CNT_W        = $clog2(BUFFER_BYTES + 1);
    localparam int LEN_W        = 16;
    localparam int FLEN_W       = 10;
    localparam int IDX_W        = 9;

    localparam logic [7:0] SYNC_ONE  = 8'hB5;
    localparam logic [7:0] SYNC_TWO  = 8'h62;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_CR     = 8'd13;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_SYNC    = 4'd1,
        PH_CLASS   = 4'd2,
        PH_ID      = 4'd3,
        PH_LEN_LO  = 4'd4,
        PH_LEN_HI  = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_CK_A    = 4'd7,
        PH_CK_B    = 4'd8
    } phase_t;

    typedef enum logic [2:0] {
        EV_BIN_DATA = 3'd0,
        EV_BIN_OK   = 3'd1,
        EV_BIN_BAD  = 3'd2,
        EV_TXT_CHAR = 3'd3,
        EV_TXT_OK   = 3'd4,
        EV_TXT_BAD  = 3'd5
    } event_kind_t;

    typedef struct packed {
        event_kind_t         kind;
        logic [7:0]          data;
        logic [7:0]          cls;
        logic [7:0]          id;
        logic [FLEN_W-1:0]   flen;
        logic [IDX_W-1:0]    idx;
    } event_t;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = 4'(c - 8'h30);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = 4'(c - 8'h41 + 8'd10);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            v = 4'(c - 8'h61 + 8'd10);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/ubxnmea_parse.sv
`timescale 1ns / 1ps
`default_nettype none

module ubxnmea_parse (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  accept,
    input  wire logic [7:0]            rx_byte,
    output ubxnmea_pkg::event_t        ev,
    output logic                       ev_valid
);

    localparam int CW = ubxnmea_pkg::CNT_W;
    localparam int LW = ubxnmea_pkg::LEN_W;

    ubxnmea_pkg::phase_t phase_reg, phase_next, eff_phase;
    logic [7:0]    class_reg, class_next;
    logic [7:0]    id_reg, id_next;
    logic [LW-1:0] length_reg, length_next;
    logic [CW-1:0] payload_count_reg, payload_count_next;
    logic [7:0]    sum_a_reg, sum_a_next;
    logic [7:0]    sum_b_reg, sum_b_next;
    logic [7:0]    rx_sum_a_reg, rx_sum_a_next;
    logic [CW-1:0] sent_count_reg, sent_count_next;
    logic [7:0]    sent_xor_reg, sent_xor_next;
    logic          star_reg, star_next;
    logic [1:0]    hex_taken_reg, hex_taken_next;
    logic [7:0]    rx_text_sum_reg, rx_text_sum_next;

    logic [7:0]    sum_a_add, sum_b_add;
    logic [LW-1:0] len_full;
    logic [CW-1:0] pc_inc, sc_inc;
    logic [3:0]    hexv;
    logic          is_term, start_sync, text_open, text_ok, len_over, pay_done, bin_ok;
    logic          star_t;
    logic [1:0]    hex_t;
    logic [7:0]    xor_t, rts_t;

    always_comb
    begin
        eff_phase = phase_reg;
        if (phase_reg == ubxnmea_pkg::PH_SYNC && rx_byte != ubxnmea_pkg::SYNC_TWO)
        begin
            eff_phase = ubxnmea_pkg::PH_IDLE;
        end
        if (phase_reg > ubxnmea_pkg::PH_CK_B)
        begin
            eff_phase = ubxnmea_pkg::PH_IDLE;
        end
    end

    assign start_sync = (eff_phase == ubxnmea_pkg::PH_IDLE) && (rx_byte == ubxnmea_pkg::SYNC_ONE);
    assign sum_a_add  = sum_a_reg + rx_byte;
    assign sum_b_add  = sum_b_reg + sum_a_add;
    assign len_full   = {rx_byte, length_reg[7:0]};
    assign len_over   = len_full > LW'(ubxnmea_pkg::BUFFER_BYTES);
    assign pc_inc     = payload_count_reg + CW'(1);
    assign pay_done   = LW'(pc_inc) >= length_reg;
    assign sc_inc     = sent_count_reg + CW'(1);
    assign hexv       = ubxnmea_pkg::hex_value(rx_byte);
    assign is_term    = (rx_byte == ubxnmea_pkg::CH_LF) || (rx_byte == ubxnmea_pkg::CH_CR);
    assign text_open  = (sent_count_reg != '0)
                     && (sent_count_reg < CW'(ubxnmea_pkg::BUFFER_BYTES - 1));
    assign bin_ok     = (sum_a_reg == rx_sum_a_reg) && (sum_b_reg == rx_byte);

    always_comb
    begin
        star_t = star_reg;
        hex_t  = hex_taken_reg;
        xor_t  = sent_xor_reg;
        rts_t  = rx_text_sum_reg;
        if (star_reg)
        begin
            if (hex_taken_reg == 2'd0)
            begin
                rts_t = {hexv, 4'h0};
                hex_t = 2'd1;
            end
            else if (hex_taken_reg == 2'd1)
            begin
                rts_t = rx_text_sum_reg | {4'h0, hexv};
                hex_t = 2'd2;
            end
        end
        else if (rx_byte == ubxnmea_pkg::CH_STAR)
        begin
            star_t = 1'b1;
        end
        else
        begin
            xor_t = sent_xor_reg ^ rx_byte;
        end
    end

    assign text_ok = star_t && (xor_t == rts_t);

    // next state
    always_comb
    begin
        phase_next         = eff_phase;
        class_next         = class_reg;
        id_next            = id_reg;
        length_next        = length_reg;
        payload_count_next = payload_count_reg;
        sum_a_next         = sum_a_reg;
        sum_b_next         = sum_b_reg;
        rx_sum_a_next      = rx_sum_a_reg;
        sent_count_next    = sent_count_reg;
        sent_xor_next      = sent_xor_reg;
        star_next          = star_reg;
        hex_taken_next     = hex_taken_reg;
        rx_text_sum_next   = rx_text_sum_reg;
        if (start_sync)
        begin
            phase_next         = ubxnmea_pkg::PH_SYNC;
            payload_count_next = '0;
            sum_a_next         = '0;
            sum_b_next         = '0;
        end
        else
        begin
            case (eff_phase)
                ubxnmea_pkg::PH_SYNC:
                begin
                    phase_next = ubxnmea_pkg::PH_CLASS;
                end
                ubxnmea_pkg::PH_CLASS:
                begin
                    class_next = rx_byte;
                    sum_a_next = sum_a_add;
                    sum_b_next = sum_b_add;
                    phase_next = ubxnmea_pkg::PH_ID;
                end
                ubxnmea_pkg::PH_ID:
                begin
                    id_next    = rx_byte;
                    sum_a_next = sum_a_add;
                    sum_b_next = sum_b_add;
                    phase_next = ubxnmea_pkg::PH_LEN_LO;
                end
                ubxnmea_pkg::PH_LEN_LO:
                begin
                    length_next = LW'(rx_byte);
                    sum_a_next  = sum_a_add;
                    sum_b_next  = sum_b_add;
                    phase_next  = ubxnmea_pkg::PH_LEN_HI;
                end
                ubxnmea_pkg::PH_LEN_HI:
                begin
                    length_next        = len_full;
                    sum_a_next         = sum_a_add;
                    sum_b_next         = sum_b_add;
                    payload_count_next = '0;
                    if (len_over)
                    begin
                        phase_next      = ubxnmea_pkg::PH_IDLE;
                        sent_count_next = '0;
                    end
                    else if (len_full != '0)
                    begin
                        phase_next = ubxnmea_pkg::PH_PAYLOAD;
                    end
                    else
                    begin
                        phase_next = ubxnmea_pkg::PH_CK_A;
                    end
                end
                ubxnmea_pkg::PH_PAYLOAD:
                begin
                    sum_a_next         = sum_a_add;
                    sum_b_next         = sum_b_add;
                    payload_count_next = pc_inc;
                    if (pay_done)
                    begin
                        phase_next = ubxnmea_pkg::PH_CK_A;
                    end
                end
                ubxnmea_pkg::PH_CK_A:
                begin
                    rx_sum_a_next = rx_byte;
                    phase_next    = ubxnmea_pkg::PH_CK_B;
                end
                ubxnmea_pkg::PH_CK_B:
                begin
                    phase_next         = ubxnmea_pkg::PH_IDLE;
                    sent_count_next    = '0;
                    payload_count_next = '0;
                end
                default:
                begin
                    phase_next = ubxnmea_pkg::PH_IDLE;
                    if (rx_byte == ubxnmea_pkg::CH_DOLLAR)
                    begin
                        sent_count_next  = CW'(1);
                        sent_xor_next    = '0;
                        star_next        = 1'b0;
                        hex_taken_next   = '0;
                        rx_text_sum_next = '0;
                    end
                    else if (!text_open)
                    begin
                        sent_count_next    = '0;
                        payload_count_next = '0;
                    end
                    else
                    begin
                        sent_count_next  = is_term ? '0 : sc_inc;
                        sent_xor_next    = xor_t;
                        star_next        = star_t;
                        hex_taken_next   = hex_t;
                        rx_text_sum_next = rts_t;
                    end
                end
            endcase
        end
    end

    // outputs
    always_comb
    begin
        ev_valid = 1'b0;
        ev       = '0;
        if (!start_sync)
        begin
            case (eff_phase)
                ubxnmea_pkg::PH_SYNC, ubxnmea_pkg::PH_CLASS, ubxnmea_pkg::PH_ID,
                ubxnmea_pkg::PH_LEN_LO, ubxnmea_pkg::PH_LEN_HI, ubxnmea_pkg::PH_CK_A:
                begin
                    ev_valid = 1'b0;
                end
                ubxnmea_pkg::PH_PAYLOAD:
                begin
                    ev_valid = 1'b1;
                    ev.kind  = ubxnmea_pkg::EV_BIN_DATA;
                    ev.data  = rx_byte;
                    ev.cls   = class_reg;
                    ev.id    = id_reg;
                    ev.flen  = ubxnmea_pkg::FLEN_W'(length_reg);
                    ev.idx   = ubxnmea_pkg::IDX_W'(payload_count_reg);
                end
                ubxnmea_pkg::PH_CK_B:
                begin
                    ev_valid = 1'b1;
                    ev.kind  = bin_ok ? ubxnmea_pkg::EV_BIN_OK : ubxnmea_pkg::EV_BIN_BAD;
                    ev.cls   = class_reg;
                    ev.id    = id_reg;
                    ev.flen  = ubxnmea_pkg::FLEN_W'(length_reg);
                end
                default:
                begin
                    if (rx_byte == ubxnmea_pkg::CH_DOLLAR)
                    begin
                        ev_valid = 1'b1;
                        ev.kind  = ubxnmea_pkg::EV_TXT_CHAR;
                        ev.data  = rx_byte;
                        ev.flen  = ubxnmea_pkg::FLEN_W'(1);
                    end
                    else if (text_open)
                    begin
                        ev_valid = 1'b1;
                        if (is_term)
                        begin
                            ev.kind = text_ok ? ubxnmea_pkg::EV_TXT_OK
                                              : ubxnmea_pkg::EV_TXT_BAD;
                        end
                        else
                        begin
                            ev.kind = ubxnmea_pkg::EV_TXT_CHAR;
                        end
                        ev.data = rx_byte;
                        ev.flen = ubxnmea_pkg::FLEN_W'(sc_inc);
                        ev.idx  = ubxnmea_pkg::IDX_W'(sent_count_reg);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= ubxnmea_pkg::PH_IDLE;
            class_reg         <= '0;
            id_reg            <= '0;
            length_reg        <= '0;
            payload_count_reg <= '0;
            sum_a_reg         <= '0;
            sum_b_reg         <= '0;
            rx_sum_a_reg      <= '0;
            sent_count_reg    <= '0;
            sent_xor_reg      <= '0;
            star_reg          <= 1'b0;
            hex_taken_reg     <= '0;
            rx_text_sum_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg         <= phase_next;
            class_reg         <= class_next;
            id_reg            <= id_next;
            length_reg        <= length_next;
            payload_count_reg <= payload_count_next;
            sum_a_reg         <= sum_a_next;
            sum_b_reg         <= sum_b_next;
            rx_sum_a_reg      <= rx_sum_a_next;
            sent_count_reg    <= sent_count_next;
            sent_xor_reg      <= sent_xor_next;
            star_reg          <= star_next;
            hex_taken_reg     <= hex_taken_next;
            rx_text_sum_reg   <= rx_text_sum_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/ubxnmea_obuf.sv
`timescale 1ns / 1ps
`default_nettype none

module ubxnmea_obuf (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire ubxnmea_pkg::event_t   push_ev,
    output logic                       full,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output ubxnmea_pkg::event_t        out_ev
);

    logic                main_valid_reg, main_valid_next;
    logic                skid_valid_reg, skid_valid_next;
    ubxnmea_pkg::event_t main_reg, main_next;
    ubxnmea_pkg::event_t skid_reg, skid_next;
    logic                pop;

    assign pop       = main_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_ev    = main_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_next       = push_ev;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_ev;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

`default_nettype wire

FILE: hdl/ubx_nmea_stream_deframer_core.sv
// Channel  | Handshake                  | Payload
// -------- | -------------------------- | ----------------------------------------------
// input    | in_valid / in_stall        | rx_byte[7:0]
// output   | out_valid / out_stall      | event_kind[2:0] data_byte[7:0] frame_class[7:0]
//          |                            | msg_id[7:0] frame_length[9:0] byte_index[8:0]
//
// One byte per cycle while in_stall is low; each byte is parsed in the cycle it transfers, and
// its event, if any, is registered into the result register, or into the skid if that is held.
// A two-entry output buffer (result register plus skid) sets the rate: in_stall rises only
// when both entries hold events, i.e. once two results wait behind a high out_stall.
// rst_n clears the frame phase, sentence state and output valids asynchronously.
`timescale 1ns / 1ps
`default_nettype none

module ubx_nmea_stream_deframer_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       event_kind,
    output logic [7:0]       data_byte,
    output logic [7:0]       frame_class,
    output logic [7:0]       msg_id,
    output logic [9:0]       frame_length,
    output logic [8:0]       byte_index
);

    logic                accept;
    logic                ev_valid;
    logic                buf_full;
    ubxnmea_pkg::event_t ev;
    ubxnmea_pkg::event_t out_ev;

    assign in_stall = buf_full;
    assign accept   = in_valid && !buf_full;

    ubxnmea_parse u_parse (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .rx_byte  (rx_byte),
        .ev       (ev),
        .ev_valid (ev_valid)
    );

    ubxnmea_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && ev_valid),
        .push_ev   (ev),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_ev    (out_ev)
    );

    assign event_kind   = out_ev.kind;
    assign data_byte    = out_ev.data;
    assign frame_class  = out_ev.cls;
    assign msg_id       = out_ev.id;
    assign frame_length = out_ev.flen;
    assign byte_index   = out_ev.idx;

endmodule

`default_nettype wire
